@@ src/assert_macros.svh @@
// Shared assertion wrappers for the segment tree block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define RARST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define RARST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rarst_pkg.sv @@
package rarst_pkg;

  localparam int POS_W = 11;
  localparam int SUM_W = 64;
  localparam int VAL_W = 32;

  localparam logic [POS_W-1:0] ACTIVE_SIZE_RST = POS_W'(1024);

  // Request codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [POS_W-1:0]        lo;
    logic [POS_W-1:0]        hi;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    bad_range;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic pop;
    logic mul;
    logic wr;
    logic fin;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic stack_empty;
  } stat_t;

endpackage

@@ src/rarst_datapath.sv @@
`include "assert_macros.svh"

module rarst_datapath #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rarst_pkg::POS_W-1:0] cfg_wdata,
  input  rarst_pkg::in_t            in_data,
  input  rarst_pkg::ctrl_t          ctrl,
  output rarst_pkg::stat_t          stat,
  output rarst_pkg::out_t           out_data
);
  import rarst_pkg::*;

  localparam int NODE_COUNT = 4 * MAX_SIZE;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int NW         = AW + 1;
  localparam int SD         = $clog2(MAX_SIZE) + 3;
  localparam int IW         = $clog2(SD);
  localparam int SPW        = $clog2(SD + 1);
  localparam int SZ_CAP     = (MAX_SIZE > 2047) ? 2047 : MAX_SIZE;

  typedef struct packed {
    logic [NW-1:0]    node;
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
  } frame_t;

  logic [POS_W-1:0] active_size_r;
  logic             cmd_r;
  logic [POS_W-1:0] lo_r, hi_r;
  logic [SUM_W-1:0] w_r;
  logic             bad_r;
  logic [SUM_W-1:0] acc_r;
  frame_t           stack_r [SD];
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [AW-1:0]    node_r;
  logic [POS_W-1:0] a_r, b_r;
  logic             full_r;
  logic [SUM_W-1:0] prod_r;
  logic [SUM_W-1:0] rd_sum_r, rd_mark_r;
  logic [AW-1:0]    clr_cnt_r;
  out_t             out_data_r;

  logic [SUM_W-1:0] sum_mem  [NODE_COUNT];
  logic [SUM_W-1:0] mark_mem [NODE_COUNT];

  logic [POS_W-1:0] size_w;
  logic             bad_w;
  logic [SPW-1:0]   sp_dec;
  frame_t           top_f;
  logic             full_w;
  logic [POS_W-1:0] s_w, e_w, ov_w, mid_w;
  logic [POS_W:0]   ab_sum;
  logic [SUM_W-1:0] op_w, p_lo, p_hi, prod_w;
  logic [NW-1:0]    left_n, right_n;
  logic             push_l, push_r;
  logic [SPW-1:0]   idx1;
  logic [AW-1:0]    wa_w;
  logic             we_sum, we_mark;
  logic [SUM_W-1:0] wd_sum, wd_mark;

  // Tree size saturates at the store capacity
  assign size_w = (active_size_r > POS_W'(SZ_CAP)) ? POS_W'(SZ_CAP) : active_size_r;
  assign bad_w  = (in_data.lo == '0) || (in_data.lo > in_data.hi) || (in_data.hi > size_w);

  assign sp_dec = sp_r - SPW'(1);
  assign top_f  = stack_r[sp_dec[IW-1:0]];

  // Node classification and overlap
  always_comb begin
    full_w = (lo_r <= a_r) && (b_r <= hi_r);
    s_w    = (a_r > lo_r) ? a_r : lo_r;
    e_w    = (b_r < hi_r) ? b_r : hi_r;
    ov_w   = e_w - s_w + POS_W'(1);
    ab_sum = {1'b0, a_r} + {1'b0, b_r};
    mid_w  = ab_sum[POS_W:1];
    op_w   = (cmd_r == CMD_ADD) ? w_r : rd_mark_r;
    p_lo   = SUM_W'(op_w[31:0]) * SUM_W'(ov_w);
    p_hi   = SUM_W'(op_w[63:32]) * SUM_W'(ov_w);
    prod_w = p_lo + {p_hi[31:0], 32'b0};
    left_n  = {node_r, 1'b0};
    right_n = {node_r, 1'b1};
    push_l = !full_w && (lo_r <= mid_w) && (left_n < NW'(NODE_COUNT));
    push_r = !full_w && (hi_r > mid_w) && (right_n < NW'(NODE_COUNT));
    idx1   = sp_r + SPW'(push_r);
  end

  // Stack pointer
  always_comb begin
    sp_nxt = sp_r;
    if (ctrl.load) begin
      sp_nxt = bad_w ? '0 : SPW'(1);
    end else if (ctrl.pop) begin
      sp_nxt = sp_dec;
    end else if (ctrl.mul) begin
      sp_nxt = sp_r + SPW'(push_r) + SPW'(push_l);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= ACTIVE_SIZE_RST;
      sp_r          <= '0;
      clr_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        active_size_r <= cfg_wdata;
      end
      sp_r <= sp_nxt;
      if (ctrl.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Request fields, node walk and accumulation
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_data.command;
      lo_r    <= in_data.lo;
      hi_r    <= in_data.hi;
      w_r     <= SUM_W'(in_data.value);
      bad_r   <= bad_w;
      acc_r   <= '0;
      stack_r[0] <= '{node: NW'(1), a: POS_W'(1), b: size_w};
    end
    if (ctrl.pop) begin
      node_r <= top_f.node[AW-1:0];
      a_r    <= top_f.a;
      b_r    <= top_f.b;
    end
    if (ctrl.mul) begin
      full_r <= full_w;
      prod_r <= prod_w;
      if (push_r) begin
        stack_r[sp_r[IW-1:0]] <= '{node: right_n, a: mid_w + POS_W'(1), b: b_r};
      end
      if (push_l) begin
        stack_r[idx1[IW-1:0]] <= '{node: left_n, a: a_r, b: mid_w};
      end
    end
    if (ctrl.wr && cmd_r == CMD_QUERY) begin
      acc_r <= acc_r + (full_r ? rd_sum_r : prod_r);
    end
    if (ctrl.fin) begin
      out_data_r.range_sum <= (bad_r || cmd_r == CMD_ADD) ? '0 : acc_r;
      out_data_r.bad_range <= bad_r;
    end
  end

  // Write port: clearing sweep or node update
  always_comb begin
    wa_w    = ctrl.clr ? clr_cnt_r : node_r;
    we_sum  = ctrl.clr || (ctrl.wr && cmd_r == CMD_ADD);
    we_mark = ctrl.clr || (ctrl.wr && cmd_r == CMD_ADD && full_r);
    wd_sum  = ctrl.clr ? '0 : rd_sum_r + prod_r;
    wd_mark = ctrl.clr ? '0 : rd_mark_r + w_r;
  end

  // Node store
  always_ff @(posedge clk) begin
    if (we_sum) begin
      sum_mem[wa_w] <= wd_sum;
    end
    if (we_mark) begin
      mark_mem[wa_w] <= wd_mark;
    end
    if (ctrl.pop) begin
      rd_sum_r  <= sum_mem[top_f.node[AW-1:0]];
      rd_mark_r <= mark_mem[top_f.node[AW-1:0]];
    end
  end

  assign stat.clear_done  = (clr_cnt_r == AW'(NODE_COUNT - 1));
  assign stat.stack_empty = (sp_r == '0);
  assign out_data         = out_data_r;

  `RARST_ASSERT(a_sp_bound, sp_r <= SPW'(SD), "node stack overflow")
  `RARST_ASSERT(a_bad_empty, (ctrl.load && bad_w) |=> (sp_r == '0), "rejected range started a walk")
  `RARST_ASSERT(a_pop_nonempty, ctrl.pop |-> (sp_r != '0), "pop from empty node stack")

endmodule

@@ src/rarst_ctrl.sv @@
`include "assert_macros.svh"

module rarst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rarst_pkg::stat_t stat,
  output rarst_pkg::ctrl_t ctrl
);
  import rarst_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_POP   = 6'b000100,
    S_MUL   = 6'b001000,
    S_WR    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_ok;

  assign fin_ok   = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.clr = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.stack_empty) begin
          state_nxt = S_FIN;
        end else begin
          ctrl.pop  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        ctrl.wr   = 1'b1;
        state_nxt = S_POP;
      end
      S_FIN: begin
        if (fin_ok) begin
          ctrl.fin  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Result valid: set on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RARST_ASSERT(a_load_walk, (in_valid && in_ready) |=> (state_r == S_POP), "request not walked")
  `RARST_ASSERT(a_fin_free, ctrl.fin |=> out_valid_r, "finished result not shown")
  `RARST_ASSERT(a_clear_block, (state_r == S_CLEAR) |-> !in_ready, "request taken while clearing")

endmodule

@@ src/range_add_range_sum_tree_top.sv @@
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | rarst_pkg::in_t
// out_     | output    | out_valid / out_ready| rarst_pkg::out_t
// cfg_     | input     | cfg_we (no wait)     | active_size
// After reset every node of the store is swept to zero; no request is taken
// then. A request walks the tree one node at a time, and each node visited costs a
// store read, a multiply and a store write, in the states POP, MUL and WR.
// A rejected range visits no node.
// A result waits in the output register; the next request is taken meanwhile,
// and its finish stalls only while the previous result is still held.
module range_add_range_sum_tree_top #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rarst_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rarst_pkg::out_t             out_data,
  input  logic                        cfg_we,
  input  logic [rarst_pkg::POS_W-1:0] cfg_wdata
);
  import rarst_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rarst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rarst_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

@@ tb/range_add_range_sum_tree_top_tb.sv @@
`timescale 1ns / 1ps

module range_add_range_sum_tree_top_tb;
  import rarst_pkg::*;

  localparam int MAX_POS   = 1024;
  localparam int NODE_CNT  = 4 * MAX_POS;
  localparam int LONG_HOLD = 400;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [POS_W-1:0]  cfg_wdata = '0;

  // Shadow of the tree and its size register
  logic [SUM_W-1:0]  shadow_sum [NODE_CNT];
  logic [SUM_W-1:0]  shadow_mark [NODE_CNT];
  logic [POS_W-1:0]  shadow_size;

  out_t              sum_q [$];
  int                errors = 0;
  bit                steady = 1'b0;
  int                hold_asked = 0;
  int                hold_taken = 0;
  int                stall_cnt = 0;
  row_t              dir_rows [$];

  range_add_range_sum_tree_top #(.MAX_SIZE(MAX_POS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned overlap(int unsigned a, int unsigned b,
                                          int unsigned lo, int unsigned hi);
    int unsigned s;
    int unsigned e;
    s = (a > lo) ? a : lo;
    e = (b < hi) ? b : hi;
    return e - s + 1;
  endfunction

  // Raise covered nodes' sum and mark, partial nodes' sum by the overlap
  function automatic void tree_raise(int unsigned node, int unsigned a, int unsigned b,
                                     int unsigned lo, int unsigned hi,
                                     logic [SUM_W-1:0] w);
    int unsigned mid;
    if (node >= NODE_CNT) return;
    if (lo <= a && b <= hi) begin
      shadow_mark[node] += w;
      shadow_sum[node]  += SUM_W'(b - a + 1) * w;
      return;
    end
    shadow_sum[node] += SUM_W'(overlap(a, b, lo, hi)) * w;
    mid = (a + b) >> 1;
    if (lo <= mid) tree_raise(node * 2, a, mid, lo, hi, w);
    if (hi > mid) tree_raise(node * 2 + 1, mid + 1, b, lo, hi, w);
  endfunction

  // Sum covered nodes, plus marks of partial nodes on the way down
  function automatic logic [SUM_W-1:0] tree_total(int unsigned node, int unsigned a,
                                                  int unsigned b, int unsigned lo,
                                                  int unsigned hi);
    int unsigned      mid;
    logic [SUM_W-1:0] acc;
    if (node >= NODE_CNT) return '0;
    if (lo <= a && b <= hi) return shadow_sum[node];
    acc = shadow_mark[node] * SUM_W'(overlap(a, b, lo, hi));
    mid = (a + b) >> 1;
    if (lo <= mid) acc += tree_total(node * 2, a, mid, lo, hi);
    if (hi > mid) acc += tree_total(node * 2 + 1, mid + 1, b, lo, hi);
    return acc;
  endfunction

  function automatic out_t apply_request(in_t r);
    out_t        res;
    int unsigned size;
    size = (shadow_size > MAX_POS) ? MAX_POS : shadow_size;
    res = '0;
    if (r.lo == 0 || r.lo > r.hi || r.hi > size) begin
      res.bad_range = 1'b1;
      return res;
    end
    if (r.command == CMD_ADD)
      tree_raise(1, 1, size, r.lo, r.hi, SUM_W'(r.value));
    else
      res.range_sum = tree_total(1, 1, size, r.lo, r.hi);
    return res;
  endfunction

  // Offer one request, hold it until taken, then pause for gap cycles
  task automatic send_req(in_t r, int gap, bit typed = 1'b0, out_t want = '0);
    out_t pred;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_request(r);
    sum_q = {sum_q, (typed ? want : pred)};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(logic [POS_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_size  = v;
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return VAL_W'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal ranges inside the tree; the rest random 11-bit noise
  function automatic in_t pick_req();
    in_t         r;
    int unsigned size;
    int unsigned a;
    int unsigned b;
    size = (shadow_size > MAX_POS) ? MAX_POS : shadow_size;
    r.command = 1'($urandom_range(0, 1));
    r.value   = pick_value();
    if (size > 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom_range(1, size);
        b = a;
      end else begin
        a = $urandom_range(1, size);
        b = $urandom_range(1, size);
        if (a > b) begin
          a = a ^ b;
          b = a ^ b;
          a = a ^ b;
        end
      end
      r.lo = POS_W'(a);
      r.hi = POS_W'(b);
    end else begin
      r.lo = POS_W'($urandom);
      r.hi = POS_W'($urandom);
      if ($urandom_range(0, 3) == 0) r.lo = '0;
    end
    return r;
  endfunction

  // Receiver: random stalls, long hold when asked, none in steady stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (hold_taken != hold_asked) begin
      out_ready  <= 1'b0;
      stall_cnt  <= LONG_HOLD;
      hold_taken <= hold_asked;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 4) begin
      out_ready <= 1'b0;
      stall_cnt <= $urandom_range(15, 60);
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected result sum=%h bad=%b", $time,
                 out_data.range_sum, out_data.bad_range);
        errors++;
      end else begin
        want = sum_q.pop_front();
        if (out_data.range_sum !== want.range_sum) begin
          $display("%0t: range_sum expected %h actual %h", $time,
                   want.range_sum, out_data.range_sum);
          errors++;
        end
        if (out_data.bad_range !== want.bad_range) begin
          $display("%0t: bad_range expected %b actual %b", $time,
                   want.bad_range, out_data.bad_range);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [POS_W-1:0] sizes [$];
    int               n;
    out_t             ok;
    out_t             bad;
    ok  = '0;
    bad = '0;
    bad.bad_range = 1'b1;
    for (int i = 0; i < NODE_CNT; i++) begin
      shadow_sum[i]  = '0;
      shadow_mark[i] = '0;
    end
    shadow_size = ACTIVE_SIZE_RST;

    // Directed requests at full size
    dir_rows = '{
      '{'{CMD_QUERY, 11'd1, 11'd1024, 32'h0}, 1'b1, ok},
      '{'{CMD_QUERY, 11'd0, 11'd5, 32'h0}, 1'b1, bad},
      '{'{CMD_ADD, 11'd9, 11'd8, 32'h5}, 1'b1, bad},
      '{'{CMD_ADD, 11'd1, 11'd1025, 32'h5}, 1'b1, bad},
      '{'{CMD_QUERY, 11'd2047, 11'd2047, 32'hffff_ffff}, 1'b1, bad},
      '{'{CMD_ADD, 11'd1, 11'd1024, 32'h7fff_ffff}, 1'b1, ok},
      '{'{CMD_ADD, 11'd1, 11'd1, 32'h8000_0000}, 1'b1, ok},
      '{'{CMD_ADD, 11'd1024, 11'd1024, 32'hffff_ffff}, 1'b1, ok},
      '{'{CMD_QUERY, 11'd1, 11'd1024, 32'h0}, 1'b0, ok},
      '{'{CMD_QUERY, 11'd1, 11'd1, 32'h0}, 1'b0, ok},
      '{'{CMD_QUERY, 11'd1024, 11'd1024, 32'h0}, 1'b0, ok},
      '{'{CMD_QUERY, 11'd512, 11'd513, 32'h1234}, 1'b0, ok},
      '{'{CMD_ADD, 11'd3, 11'd700, 32'd12345}, 1'b1, ok},
      '{'{CMD_QUERY, 11'd2, 11'd701, 32'h0}, 1'b0, ok},
      '{'{CMD_QUERY, 11'd700, 11'd1024, 32'h0}, 1'b0, ok},
      '{'{CMD_ADD, 11'd1, 11'd1024, 32'h8000_0000}, 1'b1, ok},
      '{'{CMD_QUERY, 11'd1, 11'd1024, 32'h0}, 1'b0, ok}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, pick_gap(), dir_rows[i].typed, dir_rows[i].want);

    // Resized shapes on the old contents, extremes included
    sizes = '{11'd7, 11'd1, 11'd0, 11'd2047, 11'd100, 11'd1000, 11'd33, 11'd1024};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      steady = (p == 4);
      n = (sizes[p] == 0) ? 20 : 240;
      for (int k = 0; k < n; k++) begin
        // Long receiver hold while requests keep coming back to back
        if (p == 5 && k == 10) begin
          hold_asked++;
          for (int j = 0; j < 25; j++) send_req(pick_req(), 0);
        end
        if (k == n / 2) drain();
        send_req(pick_req(), pick_gap());
      end
      steady = 1'b0;
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
